[src/mts_pkg.sv]
// mts_pkg: shared types and constants of the max tracking stack
// no dependencies; used by every other file of the block
package mts_pkg;

    localparam int MTS_STACK_DEPTH = 64;
    localparam int MTS_DATA_W      = 32;

    typedef logic [1:0] mts_status_t;

    localparam mts_status_t ST_OK        = 2'd0;
    localparam mts_status_t ST_POP_EMPTY = 2'd1;
    localparam mts_status_t ST_PUSH_FULL = 2'd2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic        capture;     // latch the input beat
        logic        push;        // perform a push
        logic        pop_read;    // start a pop: read the element top
        logic        pop_check;   // finish a pop against the cache top
        logic        load_top;    // refill cache top from memory
        logic        set_status;  // record status code
        mts_status_t code;
        logic        load_out;    // move the result into the output register
    } mts_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic op_pop;
        logic stack_full;
        logic stack_empty;
        logic need_refill;
        logic out_free;
    } mts_sts_t;

endpackage

[src/mts_ifs.sv]
// mts_ifs: valid/ready channel interfaces for request and result beats
// depends on mts_pkg
interface mts_in_if
    import mts_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [MTS_DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_out_if
    import mts_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [MTS_DATA_W-1:0] popped_value;
    logic signed [MTS_DATA_W-1:0] stack_max;
    logic                         is_empty;
    logic [1:0]                   status;

    modport source (output valid, output popped_value, output stack_max,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input popped_value, input stack_max,
                    input is_empty, input status, output ready);
endinterface

[src/mts_ctrl.sv]
// mts_ctrl: sequencing state machine of the max tracking stack
// depends on mts_pkg; drives the command struct of mts_datapath
module mts_ctrl
    import mts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mts_sts_t sts,
    output mts_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_POP_CHK  = 3'd2;
    localparam logic [2:0] S_LOAD_TOP = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.code   = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_status = 1'b1;
                if (sts.op_pop)
                begin
                    if (sts.stack_empty)
                    begin
                        cmd.code   = ST_POP_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.pop_read = 1'b1;
                        state_next   = S_POP_CHK;
                    end
                end
                else
                begin
                    if (sts.stack_full)
                    begin
                        cmd.code = ST_PUSH_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_POP_CHK:
            begin
                cmd.pop_check = 1'b1;
                state_next    = sts.need_refill ? S_LOAD_TOP : S_DONE;
            end
            S_LOAD_TOP:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/mts_datapath.sv]
// mts_datapath: element stack, max cache stack and output register
// depends on mts_pkg; sequenced by mts_ctrl
module mts_datapath
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = MTS_STACK_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mts_cmd_t                     cmd,
    output mts_sts_t                     sts,
    input  logic                         action,
    input  logic signed [MTS_DATA_W-1:0] value,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [MTS_DATA_W-1:0] popped_value,
    output logic signed [MTS_DATA_W-1:0] stack_max,
    output logic                         is_empty,
    output logic [1:0]                   status
);

    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = MTS_DATA_W + CNT_W;

    // storage
    logic [MTS_DATA_W-1:0] elem_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]    cache_mem [STACK_DEPTH];
    logic [MTS_DATA_W-1:0] elem_q_reg;
    logic [ENTRY_W-1:0]    cache_q_reg;

    // control state
    logic [CNT_W-1:0] elem_cnt_reg,  elem_cnt_next;
    logic [CNT_W-1:0] cache_cnt_reg, cache_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // cache top held in registers; entries below it sit in cache_mem
    logic signed [MTS_DATA_W-1:0] top_max_reg, top_max_next;
    logic [CNT_W-1:0]             top_cnt_reg, top_cnt_next;

    // captured beat and per-item scratch
    logic                         action_reg;
    logic signed [MTS_DATA_W-1:0] value_reg;
    logic signed [MTS_DATA_W-1:0] popped_reg;
    mts_status_t                  status_reg;

    logic signed [MTS_DATA_W-1:0] out_popped_reg;
    logic signed [MTS_DATA_W-1:0] out_max_reg;
    logic                         out_empty_reg;
    mts_status_t                  out_status_reg;

    logic [CNT_W-1:0] elem_cnt_dec;
    logic [CNT_W-1:0] cache_cnt_dec;
    logic [CNT_W-1:0] cache_cnt_dec2;
    logic             cache_nonempty;
    logic             push_new_entry;
    logic             pop_hit;
    logic             pop_drop;
    logic             refill;
    logic             out_free;

    assign elem_cnt_dec   = elem_cnt_reg - CNT_W'(1);
    assign cache_cnt_dec  = cache_cnt_reg - CNT_W'(1);
    assign cache_cnt_dec2 = cache_cnt_reg - CNT_W'(2);
    assign cache_nonempty = (cache_cnt_reg != '0);

    // push above the cached max opens a new entry
    assign push_new_entry = cache_nonempty && (value_reg != top_max_reg)
                            && (value_reg > top_max_reg)
                            && (cache_cnt_reg < CNT_W'(STACK_DEPTH));

    assign pop_hit  = cache_nonempty && (elem_q_reg == top_max_reg);
    assign pop_drop = pop_hit && (top_cnt_reg <= CNT_W'(1));
    assign refill   = pop_drop && (cache_cnt_reg > CNT_W'(1));
    assign out_free = !out_valid_reg || out_ready;

    assign sts.op_pop      = (action_reg == ACT_POP);
    assign sts.stack_full  = (elem_cnt_reg >= CNT_W'(STACK_DEPTH));
    assign sts.stack_empty = (elem_cnt_reg == '0);
    assign sts.need_refill = refill;
    assign sts.out_free    = out_free;

    always_comb
    begin
        elem_cnt_next  = elem_cnt_reg;
        cache_cnt_next = cache_cnt_reg;
        top_max_next   = top_max_reg;
        top_cnt_next   = top_cnt_reg;
        out_valid_next = out_valid_reg;

        if (cmd.push)
        begin
            elem_cnt_next = elem_cnt_reg + CNT_W'(1);
            if (!cache_nonempty)
            begin
                top_max_next   = value_reg;
                top_cnt_next   = CNT_W'(1);
                cache_cnt_next = CNT_W'(1);
            end
            else if (value_reg == top_max_reg)
            begin
                top_cnt_next = top_cnt_reg + CNT_W'(1);
            end
            else if (push_new_entry)
            begin
                top_max_next   = value_reg;
                top_cnt_next   = CNT_W'(1);
                cache_cnt_next = cache_cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.pop_read)
        begin
            elem_cnt_next = elem_cnt_dec;
        end

        if (cmd.pop_check && pop_hit)
        begin
            if (pop_drop)
            begin
                cache_cnt_next = cache_cnt_dec;
            end
            else
            begin
                top_cnt_next = top_cnt_reg - CNT_W'(1);
            end
        end

        if (cmd.load_top)
        begin
            top_max_next = cache_q_reg[ENTRY_W-1:CNT_W];
            top_cnt_next = cache_q_reg[CNT_W-1:0];
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg  <= '0;
            cache_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            elem_cnt_reg  <= elem_cnt_next;
            cache_cnt_reg <= cache_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_max_reg <= top_max_next;
        top_cnt_reg <= top_cnt_next;
        if (cmd.capture)
        begin
            action_reg <= action;
            value_reg  <= value;
            popped_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.code;
        end
        if (cmd.pop_check)
        begin
            popped_reg <= elem_q_reg;
        end
        if (cmd.load_out)
        begin
            out_popped_reg <= popped_reg;
            out_max_reg    <= ((elem_cnt_reg != '0) && cache_nonempty) ? top_max_reg : '0;
            out_empty_reg  <= (elem_cnt_reg == '0);
            out_status_reg <= status_reg;
        end
    end

    // element stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            elem_mem[elem_cnt_reg[ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.pop_read)
        begin
            elem_q_reg <= elem_mem[elem_cnt_dec[ADDR_W-1:0]];
        end
    end

    // max cache memory: old top spills on a new entry, refills after a drop
    always_ff @(posedge clk)
    begin
        if (cmd.push && push_new_entry)
        begin
            cache_mem[cache_cnt_dec[ADDR_W-1:0]] <= {top_max_reg, top_cnt_reg};
        end
        if (cmd.pop_check && refill)
        begin
            cache_q_reg <= cache_mem[cache_cnt_dec2[ADDR_W-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign stack_max    = out_max_reg;
    assign is_empty     = out_empty_reg;
    assign status       = out_status_reg;

endmodule

[src/max_tracking_stack.sv]
// max_tracking_stack: stack of signed words that reports its maximum per beat
// depends on mts_pkg, mts_ifs, mts_ctrl and mts_datapath
//
//  channel   dir  payload                                    handshake
//  in_ch     in   action, value                              valid/ready
//  out_ch    out  popped_value, stack_max, is_empty, status  valid/ready
//
// a push passes from accept through the exec and done states, a pop through exec,
// pop check and done, and also load top when the pop empties the top cache entry
// and the next one is read back from memory; the single-port reads of the element
// and cache memories set these steps; one item is in flight at a time
// reset clears the element and cache counts and the output valid; memories
// hold no reset state and are only read where written
// a stalled result waits in the output register; the next request beat is
// taken meanwhile and held before its result stage until the register frees
module max_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = MTS_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    mts_in_if.sink    in_ch,
    mts_out_if.source out_ch
);

    mts_cmd_t cmd;
    mts_sts_t sts;

    // sequencer: decides the steps of each push or pop
    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stacks, cached maximum and output register
    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (in_ch.action),
        .value        (in_ch.value),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .popped_value (out_ch.popped_value),
        .stack_max    (out_ch.stack_max),
        .is_empty     (out_ch.is_empty),
        .status       (out_ch.status)
    );

    // one item in flight: an accepted beat closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request accepted while an item is in flight");

    // result register is never overwritten while a beat is still pending
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwritten before it was taken");

    // an ignored pop reports an empty stack with zero fields
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == ST_POP_EMPTY)) |->
        (out_ch.is_empty && (out_ch.popped_value == '0) && (out_ch.stack_max == '0)))
        else $error("ignored pop with nonzero result fields");

    // an empty stack never reports a maximum
    a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.is_empty) |-> (out_ch.stack_max == '0))
        else $error("empty stack with nonzero maximum");

endmodule
